// ===== design/mefe_pkg.sv =====
`timescale 1ns / 1ps

package mefe_pkg;

  // Width in which node IDs are compared.
  localparam int NODE_ID_BITS = 32;

  typedef logic [NODE_ID_BITS-1:0] id_t;

  // Element type codes
  localparam logic [9:0] TYPE_BEAM2 = 10'd102;
  localparam logic [9:0] TYPE_BEAM3 = 10'd103;
  localparam logic [9:0] TYPE_TRI3  = 10'd203;
  localparam logic [9:0] TYPE_QUAD4 = 10'd204;
  localparam logic [9:0] TYPE_QUAD8 = 10'd208;
  localparam logic [9:0] TYPE_TET4  = 10'd304;
  localparam logic [9:0] TYPE_WEDGE = 10'd306;
  localparam logic [9:0] TYPE_HEX8  = 10'd308;
  localparam logic [9:0] TYPE_TET10 = 10'd310;
  localparam logic [9:0] TYPE_HEX20 = 10'd320;

  typedef enum logic [2:0] {
    SH_BEAM,
    SH_TRI,
    SH_QUAD,
    SH_TET,
    SH_WEDGE,
    SH_HEX
  } shape_e;

  typedef struct packed {
    logic   ok;
    shape_e shape;
  } shape_sel_t;

  typedef struct packed {
    logic [31:0] element_tag;
    logic [9:0]  type_code;
    logic [4:0]  node_count;
    logic [31:0] node_0;
    logic [31:0] node_1;
    logic [31:0] node_2;
    logic [31:0] node_3;
    logic [31:0] node_4;
    logic [31:0] node_5;
    logic [31:0] node_6;
    logic [31:0] node_7;
  } in_item_t;

  typedef struct packed {
    logic [31:0] source_tag;
    logic [2:0]  face_index;
    logic [2:0]  face_size;
    logic [31:0] face_node_a;
    logic [31:0] face_node_b;
    logic [31:0] face_node_c;
    logic [31:0] face_node_d;
    logic        last_face;
  } out_item_t;

  // One face moving through the sort stages
  typedef struct packed {
    logic [31:0]   tag;
    logic [2:0]    index;
    logic [2:0]    size;
    logic          last;
    id_t [3:0]     v;
  } face_t;

  function automatic shape_sel_t decode_shape(logic [9:0] etype, logic [4:0] cnt);
    shape_sel_t r;
    r.ok    = 1'b0;
    r.shape = SH_BEAM;
    case (etype)
      TYPE_BEAM2, TYPE_BEAM3: begin
        r.ok = 1'b1; r.shape = SH_BEAM;
      end
      TYPE_TRI3: begin
        r.ok = (cnt == 5'd3); r.shape = SH_TRI;
      end
      TYPE_QUAD4: begin
        r.ok = (cnt == 5'd4); r.shape = SH_QUAD;
      end
      TYPE_QUAD8: begin
        r.ok = (cnt == 5'd8); r.shape = SH_QUAD;
      end
      TYPE_TET4: begin
        r.ok = (cnt == 5'd4); r.shape = SH_TET;
      end
      TYPE_WEDGE: begin
        r.ok = (cnt == 5'd6); r.shape = SH_WEDGE;
      end
      TYPE_HEX8: begin
        r.ok = (cnt == 5'd8); r.shape = SH_HEX;
      end
      TYPE_TET10: begin
        r.ok = (cnt == 5'd10); r.shape = SH_TET;
      end
      TYPE_HEX20: begin
        r.ok = (cnt == 5'd20); r.shape = SH_HEX;
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] face_count(shape_e s);
    logic [2:0] n;
    case (s)
      SH_BEAM:  n = 3'd2;
      SH_TRI:   n = 3'd3;
      SH_QUAD:  n = 3'd4;
      SH_TET:   n = 3'd4;
      SH_WEDGE: n = 3'd5;
      SH_HEX:   n = 3'd6;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] face_size(shape_e s, logic [2:0] f);
    logic [2:0] n;
    case (s)
      SH_BEAM:  n = 3'd1;
      SH_TRI:   n = 3'd2;
      SH_QUAD:  n = 3'd2;
      SH_TET:   n = 3'd3;
      SH_WEDGE: n = (f < 3'd2) ? 3'd3 : 3'd4;
      SH_HEX:   n = 3'd4;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // Corner numbers of a face, slot 0 in the low bits, 3 bits per slot.
  function automatic logic [11:0] face_corners(shape_e s, logic [2:0] f);
    logic [11:0] c;
    c = '0;
    case (s)
      SH_BEAM: c = (f == 3'd0) ? 12'o0000 : 12'o0001;
      SH_TRI: begin
        case (f)
          3'd0:    c = 12'o0010;
          3'd1:    c = 12'o0021;
          default: c = 12'o0002;
        endcase
      end
      SH_QUAD: begin
        case (f)
          3'd0:    c = 12'o0010;
          3'd1:    c = 12'o0021;
          3'd2:    c = 12'o0032;
          default: c = 12'o0003;
        endcase
      end
      SH_TET: begin
        case (f)
          3'd0:    c = 12'o0210;
          3'd1:    c = 12'o0130;
          3'd2:    c = 12'o0231;
          default: c = 12'o0032;
        endcase
      end
      SH_WEDGE: begin
        case (f)
          3'd0:    c = 12'o0210;
          3'd1:    c = 12'o0543;
          3'd2:    c = 12'o3410;
          3'd3:    c = 12'o4521;
          default: c = 12'o5302;
        endcase
      end
      SH_HEX: begin
        case (f)
          3'd0:    c = 12'o3210;
          3'd1:    c = 12'o7654;
          3'd2:    c = 12'o4510;
          3'd3:    c = 12'o7623;
          3'd4:    c = 12'o4730;
          default: c = 12'o5621;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/mesh_element_face_extractor.sv =====
`timescale 1ns / 1ps

// Channel | Port                    | Dir | Moves
// --------+-------------------------+-----+---------------------------------
// input   | in_valid/in_stall/in_data    | in  | one element per item
// output  | out_valid/out_stall/out_data | out | one sorted element face per item
//
// An element gives 2 (beam), 3 (tri), 4 (quad, tet), 5 (wedge) or 6 (hex)
// faces; the face sequencer issues one face a cycle unless the gather stage
// is stalled, and the next element is taken in the cycle its last face issues.
// Unknown types and count mismatches are taken and dropped. From accept, a
// face passes through gather, two sort layers and the final layer/output.
// Reset (rst, synchronous) clears all valid bits. Stalls back up stage by
// stage; bubbles are squeezed out and nothing is lost or repeated.

module mesh_element_face_extractor (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mefe_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mefe_pkg::out_item_t  out_data
);

  // Element holding register (face sequencer source)
  logic                         elem_v;
  logic [31:0]                  elem_tag;
  mefe_pkg::shape_e             elem_shape;
  mefe_pkg::id_t [7:0]          elem_ids;
  logic [2:0]                   fidx;

  // Pipeline stages: gather, sort layer 1, sort layer 2
  logic                         s1_v, s2_v, s3_v;
  mefe_pkg::face_t              s1, s2, s3;

  logic                         out_en, s3_en, s2_en, s1_en;
  logic                         issue, issue_last, in_acc;
  mefe_pkg::shape_sel_t         dec;
  mefe_pkg::face_t              gather, layer1, layer2, layer3;
  logic [11:0]                  corners;
  logic [2:0]                   fcount;

  // Each stage loads when empty or when the one after it moves.
  assign out_en = !out_valid || !out_stall;
  assign s3_en  = !s3_v || out_en;
  assign s2_en  = !s2_v || s3_en;
  assign s1_en  = !s1_v || s2_en;

  assign fcount     = mefe_pkg::face_count(elem_shape);
  assign issue      = elem_v && s1_en;
  assign issue_last = issue && (fidx == fcount - 3'd1);
  assign in_stall   = elem_v && !issue_last;
  assign in_acc     = in_valid && !in_stall;
  assign dec        = mefe_pkg::decode_shape(in_data.type_code, in_data.node_count);

  // Gather the corner IDs of face fidx; unused slots take all ones so they
  // sort to the top and are zeroed at the end.
  always_comb begin
    corners      = mefe_pkg::face_corners(elem_shape, fidx);
    gather.tag   = elem_tag;
    gather.index = fidx;
    gather.size  = mefe_pkg::face_size(elem_shape, fidx);
    gather.last  = (fidx == fcount - 3'd1);
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < gather.size) begin
        gather.v[i] = elem_ids[corners[3*i +: 3]];
      end else begin
        gather.v[i] = '1;
      end
    end
  end

  // Four-input sorting network: (0,1)(2,3) / (0,2)(1,3) / (1,2)
  always_comb begin
    layer1 = s1;
    if (s1.v[0] > s1.v[1]) begin
      layer1.v[0] = s1.v[1];
      layer1.v[1] = s1.v[0];
    end
    if (s1.v[2] > s1.v[3]) begin
      layer1.v[2] = s1.v[3];
      layer1.v[3] = s1.v[2];
    end
  end

  always_comb begin
    layer2 = s2;
    if (s2.v[0] > s2.v[2]) begin
      layer2.v[0] = s2.v[2];
      layer2.v[2] = s2.v[0];
    end
    if (s2.v[1] > s2.v[3]) begin
      layer2.v[1] = s2.v[3];
      layer2.v[3] = s2.v[1];
    end
  end

  always_comb begin
    layer3 = s3;
    if (s3.v[1] > s3.v[2]) begin
      layer3.v[1] = s3.v[2];
      layer3.v[2] = s3.v[1];
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) >= s3.size) begin
        layer3.v[i] = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_v    <= 1'b0;
      fidx      <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        elem_v <= dec.ok;
        fidx   <= '0;
      end else if (issue) begin
        elem_v <= !issue_last;
        fidx   <= fidx + 3'd1;
      end
      if (s1_en) s1_v <= issue;
      if (s2_en) s2_v <= s1_v;
      if (s3_en) s3_v <= s2_v;
      if (out_en) out_valid <= s3_v;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      elem_tag    <= in_data.element_tag;
      elem_shape  <= dec.shape;
      elem_ids[0] <= mefe_pkg::id_t'(in_data.node_0);
      elem_ids[1] <= mefe_pkg::id_t'(in_data.node_1);
      elem_ids[2] <= mefe_pkg::id_t'(in_data.node_2);
      elem_ids[3] <= mefe_pkg::id_t'(in_data.node_3);
      elem_ids[4] <= mefe_pkg::id_t'(in_data.node_4);
      elem_ids[5] <= mefe_pkg::id_t'(in_data.node_5);
      elem_ids[6] <= mefe_pkg::id_t'(in_data.node_6);
      elem_ids[7] <= mefe_pkg::id_t'(in_data.node_7);
    end
    if (s1_en) s1 <= gather;
    if (s2_en) s2 <= layer1;
    if (s3_en) s3 <= layer2;
    if (out_en) begin
      out_data.source_tag  <= layer3.tag;
      out_data.face_index  <= layer3.index;
      out_data.face_size   <= layer3.size;
      out_data.face_node_a <= 32'(layer3.v[0]);
      out_data.face_node_b <= 32'(layer3.v[1]);
      out_data.face_node_c <= 32'(layer3.v[2]);
      out_data.face_node_d <= 32'(layer3.v[3]);
      out_data.last_face   <= layer3.last;
    end
  end

  // Sequencer never runs past the element's face list.
  assert property (@(posedge clk) disable iff (rst)
    elem_v |-> (fidx < fcount))
    else $error("face counter out of range");

  // Input is only held off while an element is being expanded.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> elem_v)
    else $error("input stalled with no element held");

  // Faces leave sorted.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.face_size >= 3'd2) |->
      (out_data.face_node_a <= out_data.face_node_b))
    else $error("face nodes not sorted");

  // Unused slots are cleared.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.face_size != 3'd4) |-> (out_data.face_node_d == '0))
    else $error("unused face slot not cleared");

  // A stalled face is held until taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled face changed");

endmodule

// ===== tb/sv/mesh_element_face_extractor_test.sv =====
`timescale 1ns / 1ps

// Face extractor bench: elements go in on the input channel. Faces are
// predicted per element and checked in order against the output channel.
// Both channels use valid/stall, are driven on the falling edge and are
// sampled on the rising edge.

module mesh_element_face_extractor_test;
  import mefe_pkg::*;

  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 20;      // quiet time after the last face
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest clean run

  // A row of the directed table. Typed rows carry their faces literally
  // (zero faces for a dropped element). The other rows go to the predictor.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    logic [1:0] n_want;
    out_item_t want1;
    out_item_t want0;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t face_expect[$];  // faces owed by the block, oldest first
  int        errors = 0;
  int        cycles = 0;
  bit        in_idle_on = 1'b1;
  bit        out_idle_on = 1'b1;
  logic      hold_req = 1'b0;
  bit        hold_seen = 1'b0;
  int        hold_cnt = 0;

  mesh_element_face_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Face predictor
  // ---------------------------------------------------------------------------
  // Each shape is a string of faces, four corner slots per face, '.' for an
  // unused slot, faces separated by a space. Quadratic types reuse the linear
  // shape, so only their corner nodes ever show up in a face.
  function automatic void predict_faces(in_item_t e);
    shape_e      sh;
    logic        ok;
    string       tbl;
    int          nf, sz, f, i, j;
    byte         ch;
    logic [31:0] ids[8];
    logic [31:0] v[4];
    logic [31:0] t;
    out_item_t   o;
    ok = 1'b0;
    sh = SH_BEAM;
    case (e.type_code)
      TYPE_BEAM2, TYPE_BEAM3: begin
        ok = 1'b1;  // beams never check the count
        sh = SH_BEAM;
      end
      TYPE_TRI3: begin
        ok = (e.node_count == 5'd3); sh = SH_TRI;
      end
      TYPE_QUAD4: begin
        ok = (e.node_count == 5'd4); sh = SH_QUAD;
      end
      TYPE_QUAD8: begin
        ok = (e.node_count == 5'd8); sh = SH_QUAD;
      end
      TYPE_TET4: begin
        ok = (e.node_count == 5'd4); sh = SH_TET;
      end
      TYPE_WEDGE: begin
        ok = (e.node_count == 5'd6); sh = SH_WEDGE;
      end
      TYPE_HEX8: begin
        ok = (e.node_count == 5'd8); sh = SH_HEX;
      end
      TYPE_TET10: begin
        ok = (e.node_count == 5'd10); sh = SH_TET;
      end
      TYPE_HEX20: begin
        ok = (e.node_count == 5'd20); sh = SH_HEX;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) return;  // unknown type or wrong count: element vanishes

    case (sh)
      SH_BEAM:  tbl = "0... 1...";
      SH_TRI:   tbl = "01.. 12.. 20..";
      SH_QUAD:  tbl = "01.. 12.. 23.. 30..";
      SH_TET:   tbl = "012. 031. 132. 230.";
      SH_WEDGE: tbl = "012. 345. 0143 1254 2035";
      default:  tbl = "0123 4567 0154 3267 0374 1265";
    endcase
    nf = (tbl.len() + 1) / 5;

    ids[0] = e.node_0; ids[1] = e.node_1; ids[2] = e.node_2; ids[3] = e.node_3;
    ids[4] = e.node_4; ids[5] = e.node_5; ids[6] = e.node_6; ids[7] = e.node_7;

    for (f = 0; f < nf; f++) begin
      sz = 0;
      for (i = 0; i < 4; i++) v[i] = '0;
      for (i = 0; i < 4; i++) begin
        ch = tbl[f*5 + i];
        if (ch != ".") begin
          v[sz] = ids[3'(ch - "0")];
          sz++;
        end
      end
      // Ascending, duplicates kept
      for (i = 1; i < sz; i++)
        for (j = i; j > 0 && v[j-1] > v[j]; j--) begin
          t = v[j]; v[j] = v[j-1]; v[j-1] = t;
        end
      o.source_tag  = e.element_tag;
      o.face_index  = 3'(f);
      o.face_size   = 3'(sz);
      o.face_node_a = v[0];
      o.face_node_b = v[1];
      o.face_node_c = v[2];
      o.face_node_d = v[3];
      o.last_face   = (f == nf - 1);
      face_expect = {face_expect, o};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall generator and face checker
  // ---------------------------------------------------------------------------
  // The hold-off is counted here so the sender can keep pushing meanwhile.
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= out_idle_on && ($urandom_range(99) < 33);
    end
  end

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (face_expect.size() == 0) begin
        $error("face with no element pending: tag %0h index %0d",
               out_data.source_tag, out_data.face_index);
        errors++;
      end else begin
        w = face_expect.pop_front();
        cmp("source_tag",  w.source_tag,  out_data.source_tag);
        cmp("face_index",  32'(w.face_index), 32'(out_data.face_index));
        cmp("face_size",   32'(w.face_size),  32'(out_data.face_size));
        cmp("face_node_a", w.face_node_a, out_data.face_node_a);
        cmp("face_node_b", w.face_node_b, out_data.face_node_b);
        cmp("face_node_c", w.face_node_c, out_data.face_node_c);
        cmp("face_node_d", w.face_node_d, out_data.face_node_d);
        cmp("last_face",   32'(w.last_face),  32'(out_data.last_face));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Element builders
  // ---------------------------------------------------------------------------
  // Nodes form an arithmetic run: node_i = base + i*step, wrapping at 32 bits.
  function automatic in_item_t elem(logic [31:0] tag, logic [9:0] ty, logic [4:0] cnt,
                                    logic [31:0] base, logic [31:0] step);
    in_item_t e;
    e.element_tag  = tag;
    e.type_code    = ty;
    e.node_count   = cnt;
    e.node_0 = base;
    e.node_1 = base + step;
    e.node_2 = base + 2 * step;
    e.node_3 = base + 3 * step;
    e.node_4 = base + 4 * step;
    e.node_5 = base + 5 * step;
    e.node_6 = base + 6 * step;
    e.node_7 = base + 7 * step;
    return e;
  endfunction

  function automatic dir_row_t checked(in_item_t e);
    dir_row_t r;
    r = '0;
    r.item = e;
    return r;
  endfunction

  function automatic dir_row_t dropped(in_item_t e);
    dir_row_t r;
    r = '0;
    r.item  = e;
    r.typed = 1'b1;  // n_want stays 0
    return r;
  endfunction

  function automatic out_item_t end_face(logic [31:0] tag, logic [2:0] idx,
                                         logic [31:0] node, logic last);
    out_item_t o;
    o = '0;
    o.source_tag  = tag;
    o.face_index  = idx;
    o.face_size   = 3'd1;
    o.face_node_a = node;
    o.last_face   = last;
    return o;
  endfunction

  // Beam: two single-node faces, first node then second, typed by hand.
  function automatic dir_row_t beam(in_item_t e, logic [31:0] n0, logic [31:0] n1);
    dir_row_t r;
    r.item   = e;
    r.typed  = 1'b1;
    r.n_want = 2'd2;
    r.want0  = end_face(e.element_tag, 3'd0, n0, 1'b0);
    r.want1  = end_face(e.element_tag, 3'd1, n1, 1'b1);
    return r;
  endfunction

  // Random element: mostly well formed, some with a wrong count, some with
  // any type code at all. Node IDs mix full range, a tiny range (repeats)
  // and extremes.
  function automatic in_item_t rand_elem();
    in_item_t    e;
    logic [31:0] ids[8];
    int          r, k, mode, m;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0: begin e.type_code = TYPE_BEAM2; e.node_count = 5'($urandom_range(31)); end
      1: begin e.type_code = TYPE_BEAM3; e.node_count = 5'($urandom_range(31)); end
      2: begin e.type_code = TYPE_TRI3;  e.node_count = 5'd3;  end
      3: begin e.type_code = TYPE_QUAD4; e.node_count = 5'd4;  end
      4: begin e.type_code = TYPE_QUAD8; e.node_count = 5'd8;  end
      5: begin e.type_code = TYPE_TET4;  e.node_count = 5'd4;  end
      6: begin e.type_code = TYPE_WEDGE; e.node_count = 5'd6;  end
      7: begin e.type_code = TYPE_HEX8;  e.node_count = 5'd8;  end
      8: begin e.type_code = TYPE_TET10; e.node_count = 5'd10; end
      default: begin e.type_code = TYPE_HEX20; e.node_count = 5'd20; end
    endcase
    if (r >= 80) e.node_count = 5'($urandom_range(31));
    if (r >= 90) e.type_code = 10'($urandom_range(1023));
    e.element_tag = $urandom;
    mode = $urandom_range(3);
    for (k = 0; k < 8; k++) begin
      m = (mode == 3) ? $urandom_range(2) : mode;
      case (m)
        0: ids[k] = $urandom;
        1: ids[k] = $urandom_range(7);
        default: begin
          case ($urandom_range(3))
            0: ids[k] = 32'h0000_0000;
            1: ids[k] = 32'hFFFF_FFFF;
            2: ids[k] = 32'h8000_0000;
            default: ids[k] = 32'h7FFF_FFFF;
          endcase
        end
      endcase
    end
    e.node_0 = ids[0]; e.node_1 = ids[1]; e.node_2 = ids[2]; e.node_3 = ids[3];
    e.node_4 = ids[4]; e.node_5 = ids[5]; e.node_6 = ids[6]; e.node_7 = ids[7];
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Entered and left on a falling edge. Faces are queued at the accepting
  // edge, before the block's pipeline can deliver the first of them.
  task automatic send_item(dir_row_t r);
    while (in_idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.item;
    do @(posedge clk); while (in_stall);
    if (r.typed) begin
      if (r.n_want > 0) face_expect = {face_expect, r.want0};
      if (r.n_want > 1) face_expect = {face_expect, r.want1};
    end else begin
      predict_faces(r.item);
    end
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    for (int k = 0; k < n; k++) send_item(checked(rand_elem()));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t plan[$];

    // Beams: ends only, count ignored, extremes of tag and node IDs
    plan = {plan, beam(elem(32'h0, TYPE_BEAM2, 5'd0, 32'hFFFF_FFFF, 32'h1),
                       32'hFFFF_FFFF, 32'h0)};
    plan = {plan, beam(elem(32'hFFFF_FFFF, TYPE_BEAM3, 5'd31, 32'h0, 32'hFFFF_FFFF),
                       32'h0, 32'hFFFF_FFFF)};
    // Every known type with its own count
    plan = {plan, checked(elem(32'h11, TYPE_TRI3,  5'd3,  32'd30, 32'hFFFF_FFF6))};
    plan = {plan, checked(elem(32'h12, TYPE_QUAD4, 5'd4,  32'd1, 32'd1))};
    plan = {plan, checked(elem(32'h13, TYPE_QUAD8, 5'd8,  32'hFFFF_FFF8, 32'd1))};
    plan = {plan, checked(elem(32'h14, TYPE_TET4,  5'd4,  32'd400, 32'hFFFF_FF9C))};
    plan = {plan, checked(elem(32'h15, TYPE_WEDGE, 5'd6,  32'h1, 32'h2AAA_AAAB))};
    plan = {plan, checked(elem(32'h16, TYPE_HEX8,  5'd8,  32'h8000, 32'hFFFF_F000))};
    plan = {plan, checked(elem(32'h17, TYPE_TET10, 5'd10, 32'h5555_5555, 32'h3333_3333))};
    plan = {plan, checked(elem(32'h18, TYPE_HEX20, 5'd20, 32'h0, 32'h8000_0000))};
    // Repeated IDs within a face
    plan = {plan, checked(elem(32'h19, TYPE_HEX8,  5'd8,  32'h5A5A_5A5A, 32'h0))};
    plan = {plan, checked(elem(32'h1A, TYPE_WEDGE, 5'd6,  32'hFFFF_FFFF, 32'h0))};
    plan = {plan, checked(elem(32'h1B, TYPE_QUAD4, 5'd4,  32'h7FFF_FFFF, 32'h1))};
    // Count mismatches: no faces
    plan = {plan, dropped(elem(32'h21, TYPE_TRI3,  5'd4,  32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h22, TYPE_QUAD8, 5'd4,  32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h23, TYPE_HEX20, 5'd31, 32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h24, TYPE_TET4,  5'd0,  32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h25, TYPE_TET10, 5'd4,  32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h26, TYPE_WEDGE, 5'd5,  32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h27, TYPE_HEX8,  5'd20, 32'd1, 32'd1))};
    // Unknown types: no faces
    plan = {plan, dropped(elem(32'h31, 10'd0,    5'd0,  32'h0, 32'h0))};
    plan = {plan, dropped(elem(32'hFFFF_FFFF, 10'd1023, 5'd31,
                               32'hFFFF_FFFF, 32'h0))};
    plan = {plan, dropped(elem(32'h33, 10'd101,  5'd2,  32'd1, 32'd1))};
    plan = {plan, dropped(elem(32'h34, 10'h2AA,  5'h15, 32'd9, 32'd3))};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) send_item(plan[k]);

    // Random traffic with idling on both sides
    send_random(120);

    // Long stretch with no idling anywhere
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    send_random(80);

    // Receiver holds off while the sender keeps offering: input must back up
    in_valid <= 1'b0;
    @(posedge clk) hold_req <= 1'b1;
    @(negedge clk);
    send_random(40);

    // Sender pauses until every face is out
    in_valid <= 1'b0;
    while (face_expect.size() != 0) @(negedge clk);

    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    send_random(120);
    in_valid <= 1'b0;

    while (face_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);  // catch any stray extra faces

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/mefe_pkg.sv
design/mesh_element_face_extractor.sv
tb/sv/mesh_element_face_extractor_test.sv
